// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/fof_pkg.sv
// Package: constants, register indexes and shared types of the OUI filter.
package fof_pkg;
    localparam int OUI_ENTRIES_DEF  = 64;
    localparam int SEEN_ENTRIES_DEF = 8;
    localparam int ADDR_W = 48;
    localparam int OUI_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RSSI_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_RX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_BSSID = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MGMT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_DATA = 3'd5;

    localparam logic [1:0] KIND_MGMT = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;

    localparam logic [1:0] SRC_TX    = 2'd0;
    localparam logic [1:0] SRC_RX    = 2'd1;
    localparam logic [1:0] SRC_BSSID = 2'd2;

    localparam int BIT_MCAST = 40;
    localparam int BIT_LOCAL = 41;

    localparam logic signed [7:0] RSSI_MIN_RST = -8'sd95;
    localparam logic [15:0]       COOLDOWN_RST = 16'd5000;

    typedef struct packed {
        logic [ADDR_W-1:0] mac;
        logic [1:0]        source;
    } cand_t;

    typedef struct packed {
        logic hit;
        logic emit;
    } dd_res_t;
endpackage

// File: hw/rtl/fof_oui_lane.sv
// One lane: OUI lookup of one address against the whole table.
module fof_oui_lane
    import fof_pkg::*;
#(
    parameter int OUI_ENTRIES = OUI_ENTRIES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [OUI_ENTRIES-1:0]        tbl_en,
    input  logic [OUI_ENTRIES*OUI_W-1:0]  tbl_oui,
    input  logic [ADDR_W-1:0]             addr,
    input  logic                          guard,
    output logic                          hit_reg
);
    logic [OUI_ENTRIES-1:0] match;
    logic                   hit_next;

    always_comb
    begin
        for (int i = 0; i < OUI_ENTRIES; i++)
        begin
            match[i] = tbl_en[i] && (tbl_oui[i*OUI_W +: OUI_W] == addr[ADDR_W-1 -: OUI_W]);
        end
        hit_next = guard && !addr[BIT_LOCAL] && (|match);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else
            hit_reg <= hit_next;
    end
endmodule

// File: hw/rtl/fof_dedupe.sv
// Dedupe table: recently seen MAC addresses with time stamps.
module fof_dedupe
    import fof_pkg::*;
#(
    parameter int SEEN_ENTRIES = SEEN_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              check,
    input  logic [ADDR_W-1:0] mac,
    input  logic [31:0]       now_ms,
    input  logic [15:0]       cooldown_ms,
    output dd_res_t           res
);
    localparam int PW = (SEEN_ENTRIES > 1) ? $clog2(SEEN_ENTRIES) : 1;

    logic [ADDR_W-1:0]       mac_reg  [SEEN_ENTRIES];
    logic [31:0]             time_reg [SEEN_ENTRIES];
    logic [SEEN_ENTRIES-1:0] valid_reg, valid_next;
    logic [PW-1:0]           ptr_reg, ptr_next;
    logic                    found;
    logic [PW-1:0]           fidx;
    logic [31:0]             age;
    logic                    in_cooldown;

    always_comb
    begin
        found = 1'b0;
        fidx  = '0;
        for (int i = SEEN_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && mac_reg[i] == mac)
            begin
                found = 1'b1;
                fidx  = PW'(i);
            end
        end
        age         = now_ms - time_reg[fidx];
        in_cooldown = age < {16'd0, cooldown_ms};
        res.hit  = found;
        res.emit = !(found && in_cooldown);
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        if (check && !found)
        begin
            valid_next[ptr_reg] = 1'b1;
            ptr_next = (ptr_reg == PW'(SEEN_ENTRIES - 1)) ? '0 : ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (check)
        begin
            if (!found)
            begin
                mac_reg[ptr_reg]  <= mac;
                time_reg[ptr_reg] <= now_ms;
            end
            else if (!in_cooldown)
                time_reg[fidx] <= now_ms;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_ptr_range, clk, rst_n, 1'b1, ptr_reg <= PW'(SEEN_ENTRIES - 1))
    `ASSERT_NEXT(a_insert_valid, clk, rst_n, check && !found, valid_reg[$past(ptr_reg)])
    `ASSERT_IMPL(a_miss_emits, clk, rst_n, !found, res.emit)
endmodule

// File: hw/rtl/frame_oui_filter_with_dedupe_top.sv
// Top level: frame OUI filter with three lookup lanes and a dedupe merge.
//
// Usage: pulse start with mode=0 to load one OUI table entry (no alert),
// or mode=1 with a frame header. A transaction is accepted when start is
// high and busy is low. Configuration: cfg_we/cfg_index/cfg_data write one
// register at once; write only while busy is low.
// Frame flow: the accepting edge registers the header and applies the kind
// filter; in the lookup step three parallel lanes look up transmitter,
// receiver and BSSID against the OUI table (one lane per address) and
// register the hits; merge steps S0, S1, S2 then pass the hits in order
// transmitter, receiver, BSSID through the shared dedupe table, one address
// per cycle; alerts appear on alert_valid for one cycle each; last marks
// the final one. A frame that passes the kind and rssi filter holds busy
// through lookup and merge, taking no new frame; if BSSID emits while
// an earlier alert is held, busy also holds through the trailing alert
// slot. Load items and dropped frames leave busy low and may follow every cycle.
// The receiver cannot stall: every alert_valid cycle is a delivered transaction.
// Reset clears the OUI enable bits, dedupe valid bits, the insert pointer
// and restores register defaults; no clearing pass is needed.
module frame_oui_filter_with_dedupe_top
    import fof_pkg::*;
#(
    parameter int OUI_ENTRIES  = OUI_ENTRIES_DEF,
    parameter int SEEN_ENTRIES = SEEN_ENTRIES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   mode,
    input  logic [5:0]             entry_index,
    input  logic [23:0]            entry_oui,
    input  logic                   entry_enable,
    input  logic [1:0]             frame_kind,
    input  logic signed [7:0]      rssi,
    input  logic [3:0]             channel,
    input  logic [47:0]            addr_receiver,
    input  logic [47:0]            addr_transmitter,
    input  logic [47:0]            addr_bssid,
    input  logic [31:0]            now_ms,
    output logic                   alert_valid,
    output logic [47:0]            alert_mac,
    output logic [1:0]             alert_source,
    output logic signed [7:0]      alert_rssi,
    output logic [3:0]             alert_channel,
    output logic                   last
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOK = 3'd1;
    localparam logic [2:0] ST_S0   = 3'd2;
    localparam logic [2:0] ST_S1   = 3'd3;
    localparam logic [2:0] ST_S2   = 3'd4;

    // Configuration registers.
    logic signed [7:0] rssi_min_reg;
    logic [15:0]       cooldown_reg;
    logic              chk_rx_reg, chk_bssid_reg, acc_mgmt_reg, acc_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rssi_min_reg  <= RSSI_MIN_RST;
            cooldown_reg  <= COOLDOWN_RST;
            chk_rx_reg    <= 1'b1;
            chk_bssid_reg <= 1'b0;
            acc_mgmt_reg  <= 1'b1;
            acc_data_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RSSI_MIN:    rssi_min_reg  <= cfg_data[7:0];
                REG_COOLDOWN:    cooldown_reg  <= cfg_data;
                REG_CHECK_RX:    chk_rx_reg    <= cfg_data[0];
                REG_CHECK_BSSID: chk_bssid_reg <= cfg_data[0];
                REG_ACCEPT_MGMT: acc_mgmt_reg  <= cfg_data[0];
                REG_ACCEPT_DATA: acc_data_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // OUI table: enable bits reset, OUI payload plain flops.
    logic [OUI_ENTRIES-1:0]       tbl_en_reg;
    logic [OUI_ENTRIES*OUI_W-1:0] tbl_oui_reg;
    logic                         accept;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tbl_en_reg <= '0;
        else if (accept && !mode && ({26'd0, entry_index} < OUI_ENTRIES))
            tbl_en_reg[entry_index[$clog2(OUI_ENTRIES > 1 ? OUI_ENTRIES : 2)-1:0]] <= entry_enable;
    end

    always_ff @(posedge clk)
    begin
        if (accept && !mode && ({26'd0, entry_index} < OUI_ENTRIES))
            tbl_oui_reg[entry_index * OUI_W +: OUI_W] <= entry_oui;
    end

    // Frame header capture.
    logic [2:0]        state_reg, state_next;
    logic [47:0]       a_tx_reg, a_rx_reg, a_bs_reg;
    logic [31:0]       now_reg;
    logic signed [7:0] rssi_reg;
    logic [3:0]        chan_reg;
    logic              mgmt_reg;
    logic              frame_ok;

    always_comb
    begin
        frame_ok = ((frame_kind == KIND_MGMT && acc_mgmt_reg) ||
                    (frame_kind == KIND_DATA && acc_data_reg)) && !(rssi < rssi_min_reg);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_tx_reg <= addr_transmitter;
            a_rx_reg <= addr_receiver;
            a_bs_reg <= addr_bssid;
            now_reg  <= now_ms;
            rssi_reg <= rssi;
            chan_reg <= channel;
            mgmt_reg <= (frame_kind == KIND_MGMT);
        end
    end

    // Lanes.
    logic hit_tx, hit_rx, hit_bs;
    fof_oui_lane #(.OUI_ENTRIES(OUI_ENTRIES)) u_lane_tx (
        .clk(clk), .rst_n(rst_n), .tbl_en(tbl_en_reg), .tbl_oui(tbl_oui_reg),
        .addr(a_tx_reg), .guard(1'b1), .hit_reg(hit_tx));
    fof_oui_lane #(.OUI_ENTRIES(OUI_ENTRIES)) u_lane_rx (
        .clk(clk), .rst_n(rst_n), .tbl_en(tbl_en_reg), .tbl_oui(tbl_oui_reg),
        .addr(a_rx_reg), .guard(chk_rx_reg && !a_rx_reg[BIT_MCAST]), .hit_reg(hit_rx));
    fof_oui_lane #(.OUI_ENTRIES(OUI_ENTRIES)) u_lane_bs (
        .clk(clk), .rst_n(rst_n), .tbl_en(tbl_en_reg), .tbl_oui(tbl_oui_reg),
        .addr(a_bs_reg), .guard(chk_bssid_reg && mgmt_reg), .hit_reg(hit_bs));

    // Merge: serial dedupe in source order.
    cand_t      cand;
    logic       want;
    dd_res_t    dd;

    always_comb
    begin
        case (state_reg)
            ST_S0:   begin cand = '{mac: a_tx_reg, source: SRC_TX};    want = hit_tx; end
            ST_S1:   begin cand = '{mac: a_rx_reg, source: SRC_RX};    want = hit_rx; end
            ST_S2:   begin cand = '{mac: a_bs_reg, source: SRC_BSSID}; want = hit_bs; end
            default: begin cand = '{mac: a_tx_reg, source: SRC_TX};    want = 1'b0;   end
        endcase
    end

    fof_dedupe #(.SEEN_ENTRIES(SEEN_ENTRIES)) u_dedupe (
        .clk(clk), .rst_n(rst_n), .check(want), .mac(cand.mac), .now_ms(now_reg),
        .cooldown_ms(cooldown_reg), .res(dd));

    // Hold one pending alert so that last can be decided when the next emits.
    logic        hold_v_reg;
    cand_t       hold_reg;
    logic        emit;
    logic        done;
    logic        tail_v_reg;

    assign emit = want && dd.emit;
    assign done = (state_reg == ST_S2);

    // The lane hits are registered at the end of the lookup cycle, so always
    // advance to the merge steps; each step checks its own hit.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && mode && frame_ok) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_S0;
            ST_S0:   state_next = ST_S1;
            ST_S1:   state_next = ST_S2;
            ST_S2:   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            hold_v_reg  <= 1'b0;
            alert_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Release the held alert when a newer one arrives or the frame ends.
            alert_valid <= tail_v_reg || (hold_v_reg && (emit || done)) || (done && emit);
            if (emit)
                hold_v_reg <= !done;
            else if (done)
                hold_v_reg <= 1'b0;
        end
    end

    // Output registers; in the final step two alerts may be due at once,
    // so the held one goes first and the new one follows in the cycle after it.
    cand_t tail_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tail_v_reg <= 1'b0;
        else
            tail_v_reg <= done && emit && hold_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            hold_reg <= cand;
        if (done && emit)
            tail_reg <= cand;
        if (tail_v_reg)
        begin
            alert_mac    <= tail_reg.mac;
            alert_source <= tail_reg.source;
            last         <= 1'b1;
        end
        else if (hold_v_reg && (emit || done))
        begin
            alert_mac    <= hold_reg.mac;
            alert_source <= hold_reg.source;
            last         <= done && !emit;
        end
        else
        begin
            alert_mac    <= cand.mac;
            alert_source <= cand.source;
            last         <= 1'b1;
        end
        alert_rssi    <= rssi_reg;
        alert_channel <= chan_reg;
    end

    // Busy through the frame and the trailing alert slot.
    logic tail_out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tail_out_reg <= 1'b0;
        else
            tail_out_reg <= tail_v_reg;
    end
    assign busy = (state_reg != ST_IDLE) || tail_v_reg || tail_out_reg;

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, busy)
    `ASSERT_NEXT(a_tail_last, clk, rst_n, tail_v_reg, alert_valid && last)
    `ASSERT_IMPL(a_want_in_merge, clk, rst_n, want,
                 state_reg == ST_S0 || state_reg == ST_S1 || state_reg == ST_S2)
endmodule
